[design/psd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, region codes and inter-stage types for the point to
// segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int COORD_BITS = 16;             // input coordinate, signed
   localparam int DIFF_BITS  = COORD_BITS + 1; // coordinate difference
   localparam int PROD_BITS  = 2 * DIFF_BITS;  // signed product of two diffs
   localparam int SUM_BITS   = PROD_BITS + 2;  // sum of three products
   localparam int MAG_BITS   = PROD_BITS;      // cross component magnitude
   localparam int HALF_BITS  = MAG_BITS / 2;   // split for squaring
   localparam int DEN_BITS   = SUM_BITS;       // squared segment length
   localparam int NUM_BITS   = 2 * MAG_BITS + 2;
   localparam int DIST_BITS  = 17;
   localparam int QUOT_BITS  = 2 * DIST_BITS;  // quotient bits kept

   typedef enum logic [1:0] {
      REGION_ENDPOINT = 2'd0,
      REGION_START    = 2'd1,
      REGION_END      = 2'd2,
      REGION_INTERIOR = 2'd3
   } region_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // geometry front end result
   typedef struct packed {
      region_type                  region;
      logic [DEN_BITS-1:0]         den;
      logic [SUM_BITS-1:0]         norm;
      logic [2:0][MAG_BITS-1:0]    mag;
   } geom_type;

   // squared distance as a ratio
   typedef struct packed {
      region_type          region;
      logic [NUM_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
   } ratio_type;

endpackage

[design/psd_geom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_geom
// Three stages: coordinate differences, products, then dot and cross sums
// with region selection.
// ----------------------------------------------------------------------------
module psd_geom (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  psd_pkg::coord_type  a [3],
   input  psd_pkg::coord_type  b [3],
   input  psd_pkg::coord_type  p [3],
   output logic                out_valid,
   output psd_pkg::geom_type   out_geom
);
   import psd_pkg::*;

   // stage 1 registers
   logic signed [DIFF_BITS-1:0] u_ff [3], v_ff [3], e_ff [3], f_ff [3];
   logic signed [DIFF_BITS-1:0] u_in [3], v_in [3], e_in [3], f_in [3];
   logic on_a_ff, on_b_ff, degen_ff, on_a_in, on_b_in, degen_in;
   logic valid1_ff;

   // stage 2 registers
   logic signed [PROD_BITS-1:0] cr_ff [6], dve_ff [3], dfe_ff [3];
   logic signed [PROD_BITS-1:0] nv_ff [3], nu_ff [3], ne_ff [3];
   logic signed [PROD_BITS-1:0] cr_in [6], dve_in [3], dfe_in [3];
   logic signed [PROD_BITS-1:0] nv_in [3], nu_in [3], ne_in [3];
   logic on_a2_ff, on_b2_ff, degen2_ff;
   logic valid2_ff;

   // stage 3 registers
   geom_type geom_ff, geom_in;
   logic     valid3_ff;

   logic signed [SUM_BITS-1:0]    dot_ve, dot_fe;
   logic [SUM_BITS-1:0]           norm_v, norm_u, norm_e;
   logic signed [PROD_BITS:0]     cross_val [3];

   // differences and equality flags
   always_comb begin
      on_a_in  = 1'b1;
      on_b_in  = 1'b1;
      degen_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         u_in[i] = DIFF_BITS'(a[i]) - DIFF_BITS'(p[i]);
         v_in[i] = DIFF_BITS'(b[i]) - DIFF_BITS'(p[i]);
         e_in[i] = DIFF_BITS'(b[i]) - DIFF_BITS'(a[i]);
         f_in[i] = DIFF_BITS'(p[i]) - DIFF_BITS'(a[i]);
         if (a[i] != p[i]) on_a_in = 1'b0;
         if (b[i] != p[i]) on_b_in = 1'b0;
         if (a[i] != b[i]) degen_in = 1'b0;
      end
   end

   // all products in parallel
   always_comb begin
      cr_in[0] = PROD_BITS'(u_ff[1]) * PROD_BITS'(v_ff[2]);
      cr_in[1] = PROD_BITS'(u_ff[2]) * PROD_BITS'(v_ff[1]);
      cr_in[2] = PROD_BITS'(u_ff[2]) * PROD_BITS'(v_ff[0]);
      cr_in[3] = PROD_BITS'(u_ff[0]) * PROD_BITS'(v_ff[2]);
      cr_in[4] = PROD_BITS'(u_ff[0]) * PROD_BITS'(v_ff[1]);
      cr_in[5] = PROD_BITS'(u_ff[1]) * PROD_BITS'(v_ff[0]);
      for (int i = 0; i < 3; i++) begin
         dve_in[i] = PROD_BITS'(v_ff[i]) * PROD_BITS'(e_ff[i]);
         dfe_in[i] = PROD_BITS'(f_ff[i]) * PROD_BITS'(e_ff[i]);
         nv_in[i]  = PROD_BITS'(v_ff[i]) * PROD_BITS'(v_ff[i]);
         nu_in[i]  = PROD_BITS'(u_ff[i]) * PROD_BITS'(u_ff[i]);
         ne_in[i]  = PROD_BITS'(e_ff[i]) * PROD_BITS'(e_ff[i]);
      end
   end

   // sums and region decision
   always_comb begin
      dot_ve = SUM_BITS'(dve_ff[0]) + SUM_BITS'(dve_ff[1]) + SUM_BITS'(dve_ff[2]);
      dot_fe = SUM_BITS'(dfe_ff[0]) + SUM_BITS'(dfe_ff[1]) + SUM_BITS'(dfe_ff[2]);
      norm_v = SUM_BITS'(nv_ff[0]) + SUM_BITS'(nv_ff[1]) + SUM_BITS'(nv_ff[2]);
      norm_u = SUM_BITS'(nu_ff[0]) + SUM_BITS'(nu_ff[1]) + SUM_BITS'(nu_ff[2]);
      norm_e = SUM_BITS'(ne_ff[0]) + SUM_BITS'(ne_ff[1]) + SUM_BITS'(ne_ff[2]);
      cross_val[0] = (PROD_BITS+1)'(cr_ff[0]) - (PROD_BITS+1)'(cr_ff[1]);
      cross_val[1] = (PROD_BITS+1)'(cr_ff[2]) - (PROD_BITS+1)'(cr_ff[3]);
      cross_val[2] = (PROD_BITS+1)'(cr_ff[4]) - (PROD_BITS+1)'(cr_ff[5]);
      for (int i = 0; i < 3; i++) begin
         geom_in.mag[i] = cross_val[i][PROD_BITS] ? MAG_BITS'(-cross_val[i])
                                                   : MAG_BITS'(cross_val[i]);
      end
      geom_in.den = DEN_BITS'(1);
      if (on_a2_ff || on_b2_ff) begin
         geom_in.region = REGION_ENDPOINT;
         geom_in.norm   = '0;
      end else if (dot_ve[SUM_BITS-1]) begin
         geom_in.region = REGION_END;
         geom_in.norm   = norm_v;
      end else if (degen2_ff || dot_fe[SUM_BITS-1]) begin
         geom_in.region = REGION_START;
         geom_in.norm   = norm_u;
      end else begin
         geom_in.region = REGION_INTERIOR;
         geom_in.norm   = '0;
         geom_in.den    = norm_e;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      u_ff      <= u_in;
      v_ff      <= v_in;
      e_ff      <= e_in;
      f_ff      <= f_in;
      on_a_ff   <= on_a_in;
      on_b_ff   <= on_b_in;
      degen_ff  <= degen_in;
      cr_ff     <= cr_in;
      dve_ff    <= dve_in;
      dfe_ff    <= dfe_in;
      nv_ff     <= nv_in;
      nu_ff     <= nu_in;
      ne_ff     <= ne_in;
      on_a2_ff  <= on_a_ff;
      on_b2_ff  <= on_b_ff;
      degen2_ff <= degen_ff;
      geom_ff   <= geom_in;
   end

   assign out_valid = valid3_ff;
   assign out_geom  = geom_ff;

endmodule

[design/psd_square.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_square
// Squares the three cross components as half-width partial products and
// builds the numerator of the squared distance ratio. Three stages.
// ----------------------------------------------------------------------------
module psd_square (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  psd_pkg::geom_type   in_geom,
   output logic                out_valid,
   output psd_pkg::ratio_type  out_ratio
);
   import psd_pkg::*;

   localparam int SQ_BITS = 2 * MAG_BITS;

   logic [MAG_BITS-1:0] hh_ff [3], hl_ff [3], ll_ff [3];
   logic [MAG_BITS-1:0] hh_in [3], hl_in [3], ll_in [3];
   logic [SQ_BITS-1:0]  sq_ff [3], sq_in [3];
   geom_type            g4_ff, g5_ff;
   ratio_type           ratio_ff, ratio_in;
   logic                valid4_ff, valid5_ff, valid6_ff;

   // partial products, high and low halves
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hh_in[i] = MAG_BITS'(in_geom.mag[i][MAG_BITS-1:HALF_BITS])
                  * MAG_BITS'(in_geom.mag[i][MAG_BITS-1:HALF_BITS]);
         hl_in[i] = MAG_BITS'(in_geom.mag[i][MAG_BITS-1:HALF_BITS])
                  * MAG_BITS'(in_geom.mag[i][HALF_BITS-1:0]);
         ll_in[i] = MAG_BITS'(in_geom.mag[i][HALF_BITS-1:0])
                  * MAG_BITS'(in_geom.mag[i][HALF_BITS-1:0]);
      end
   end

   // recombine each square
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (SQ_BITS'(hh_ff[i]) << (2 * HALF_BITS))
                  + (SQ_BITS'(hl_ff[i]) << (HALF_BITS + 1))
                  + SQ_BITS'(ll_ff[i]);
      end
   end

   // numerator: squared cross product norm inside, plain squared length otherwise
   always_comb begin
      ratio_in.region = g5_ff.region;
      ratio_in.den    = g5_ff.den;
      if (g5_ff.region == REGION_INTERIOR) begin
         ratio_in.num = NUM_BITS'(sq_ff[0]) + NUM_BITS'(sq_ff[1]) + NUM_BITS'(sq_ff[2]);
      end else begin
         ratio_in.num = NUM_BITS'(g5_ff.norm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else begin
         valid4_ff <= in_valid;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
      end
   end

   always_ff @(posedge clock) begin
      hh_ff    <= hh_in;
      hl_ff    <= hl_in;
      ll_ff    <= ll_in;
      g4_ff    <= in_geom;
      sq_ff    <= sq_in;
      g5_ff    <= g4_ff;
      ratio_ff <= ratio_in;
   end

   assign out_valid = valid6_ff;
   assign out_ratio = ratio_ff;

endmodule

[design/psd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage. A first stage
// flags quotients too large for the root; those saturate to all ones.
// ----------------------------------------------------------------------------
module psd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  psd_pkg::ratio_type    in_ratio,
   output logic                  out_valid,
   output logic [psd_pkg::QUOT_BITS-1:0] out_quot,
   output psd_pkg::region_type   out_region
);
   import psd_pkg::*;

   localparam int STAGES = QUOT_BITS + 1;

   logic [NUM_BITS-1:0]  rem_ff  [STAGES];
   logic [DEN_BITS-1:0]  den_ff  [STAGES];
   logic [QUOT_BITS-1:0] quot_ff [STAGES];
   logic                 ovf_ff  [STAGES];
   region_type           reg_ff  [STAGES];
   logic [STAGES-1:0]    valid_ff;

   // overflow check stage
   always_ff @(posedge clock) begin
      rem_ff[0]  <= in_ratio.num;
      den_ff[0]  <= in_ratio.den;
      quot_ff[0] <= '0;
      ovf_ff[0]  <= in_ratio.num >= (NUM_BITS'(in_ratio.den) << QUOT_BITS);
      reg_ff[0]  <= in_ratio.region;
   end

   // one quotient bit per stage, most significant first
   for (genvar i = 1; i < STAGES; i++) begin : g_step
      localparam int K = QUOT_BITS - i;
      logic [NUM_BITS-1:0]  trial;
      logic [NUM_BITS-1:0]  rem_in;
      logic [QUOT_BITS-1:0] quot_in;

      always_comb begin
         trial   = NUM_BITS'(den_ff[i-1]) << K;
         rem_in  = rem_ff[i-1];
         quot_in = quot_ff[i-1];
         if (rem_ff[i-1] >= trial) begin
            rem_in     = rem_ff[i-1] - trial;
            quot_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         den_ff[i]  <= den_ff[i-1];
         quot_ff[i] <= quot_in;
         ovf_ff[i]  <= ovf_ff[i-1];
         reg_ff[i]  <= reg_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_quot   = ovf_ff[STAGES-1] ? '1 : quot_ff[STAGES-1];
   assign out_region = reg_ff[STAGES-1];

endmodule

[design/psd_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined floor square root, one result bit per stage by trial squaring.
// ----------------------------------------------------------------------------
module psd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [psd_pkg::QUOT_BITS-1:0]  in_value,
   input  psd_pkg::region_type            in_region,
   output logic                           out_valid,
   output logic [psd_pkg::DIST_BITS-1:0]  out_root,
   output psd_pkg::region_type            out_region
);
   import psd_pkg::*;

   logic [QUOT_BITS-1:0] val_ff  [DIST_BITS];
   logic [DIST_BITS-1:0] root_ff [DIST_BITS];
   region_type           reg_ff  [DIST_BITS];
   logic [DIST_BITS-1:0] valid_ff;

   for (genvar i = 0; i < DIST_BITS; i++) begin : g_bit
      localparam int B = DIST_BITS - 1 - i;
      logic [QUOT_BITS-1:0] val_prev;
      logic [DIST_BITS-1:0] root_prev, trial, root_in;
      region_type           reg_prev;

      // first stage takes the divider output
      if (i == 0) begin : g_first
         assign val_prev  = in_value;
         assign root_prev = '0;
         assign reg_prev  = in_region;
      end else begin : g_next
         assign val_prev  = val_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign reg_prev  = reg_ff[i-1];
      end

      always_comb begin
         trial   = root_prev | (DIST_BITS'(1) << B);
         root_in = root_prev;
         if (QUOT_BITS'(trial) * QUOT_BITS'(trial) <= val_prev) root_in = trial;
      end

      always_ff @(posedge clock) begin
         val_ff[i]  <= val_prev;
         root_ff[i] <= root_in;
         reg_ff[i]  <= reg_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DIST_BITS-2:0], in_valid};
      end
   end

   assign out_valid  = valid_ff[DIST_BITS-1];
   assign out_root   = root_ff[DIST_BITS-1];
   assign out_region = reg_ff[DIST_BITS-1];

endmodule

[design/point_segment_distance_3d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Shortest distance from a point to a 3D segment, signed Q8.8 in, floor
// square root distance out with a region code.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start high with segment start, segment end and query point on the
//   req_ ports; the beat is taken at any edge where start is high and busy
//   is low. busy never rises: a new beat may be taken in every cycle.
//   Each beat yields one result beat, shown for one cycle with rsp_strobe
//   high on rsp_distance and rsp_region. Results come out in order.
//   Pipeline: 3 geometry stages, 3 squaring stages, 35 divider stages (one
//   overflow check plus one per quotient bit) and 17 root stages, one bit
//   each. Throughput is one item per clock.
//   Reset empties the pipeline: beats in flight are dropped and no strobe
//   follows. There is no configuration and nothing stored between items.
//   The receiver cannot stall the output, so nothing is held back.
// ----------------------------------------------------------------------------
module point_segment_distance_3d (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  psd_pkg::coord_type             req_start_x,
   input  psd_pkg::coord_type             req_start_y,
   input  psd_pkg::coord_type             req_start_z,
   input  psd_pkg::coord_type             req_end_x,
   input  psd_pkg::coord_type             req_end_y,
   input  psd_pkg::coord_type             req_end_z,
   input  psd_pkg::coord_type             req_query_x,
   input  psd_pkg::coord_type             req_query_y,
   input  psd_pkg::coord_type             req_query_z,
   output logic                           rsp_strobe,
   output logic [psd_pkg::DIST_BITS-1:0]  rsp_distance,
   output logic [1:0]                     rsp_region
);
   import psd_pkg::*;

   coord_type  pa [3], pb [3], pq [3];
   logic       geom_valid, sq_valid, div_valid;
   geom_type   geom;
   ratio_type  ratio;
   logic [QUOT_BITS-1:0] quot;
   region_type div_region, out_region;

   assign busy = 1'b0;

   assign pa[0] = req_start_x;
   assign pa[1] = req_start_y;
   assign pa[2] = req_start_z;
   assign pb[0] = req_end_x;
   assign pb[1] = req_end_y;
   assign pb[2] = req_end_z;
   assign pq[0] = req_query_x;
   assign pq[1] = req_query_y;
   assign pq[2] = req_query_z;

   psd_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .a         (pa),
      .b         (pb),
      .p         (pq),
      .out_valid (geom_valid),
      .out_geom  (geom)
   );

   psd_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_geom   (geom),
      .out_valid (sq_valid),
      .out_ratio (ratio)
   );

   psd_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sq_valid),
      .in_ratio   (ratio),
      .out_valid  (div_valid),
      .out_quot   (quot),
      .out_region (div_region)
   );

   psd_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_value   (quot),
      .in_region  (div_region),
      .out_valid  (rsp_strobe),
      .out_root   (rsp_distance),
      .out_region (out_region)
   );

   assign rsp_region = out_region;

   // an endpoint hit always reports zero distance
   a_endpoint_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && out_region == REGION_ENDPOINT |-> rsp_distance == '0)
      else $error("endpoint result with nonzero distance");

   // interior case never divides by a zero length
   a_interior_den: assert property (@(posedge clock) disable iff (reset)
      geom_valid && geom.region == REGION_INTERIOR |-> geom.den != '0)
      else $error("interior region with zero segment length");

   // non-interior ratios use a unit denominator
   a_unit_den: assert property (@(posedge clock) disable iff (reset)
      sq_valid && ratio.region != REGION_INTERIOR |-> ratio.den == DEN_BITS'(1))
      else $error("endpoint distance with non-unit denominator");

endmodule

[bench/point_segment_distance_3d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d_checker
// Watches the request and result beats of the distance block, works out the
// distance and region of every accepted request and compares each result
// beat, in order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  psd_pkg::coord_type             req_start_x,
   input  psd_pkg::coord_type             req_start_y,
   input  psd_pkg::coord_type             req_start_z,
   input  psd_pkg::coord_type             req_end_x,
   input  psd_pkg::coord_type             req_end_y,
   input  psd_pkg::coord_type             req_end_z,
   input  psd_pkg::coord_type             req_query_x,
   input  psd_pkg::coord_type             req_query_y,
   input  psd_pkg::coord_type             req_query_z,
   input  logic                           rsp_strobe,
   input  logic [psd_pkg::DIST_BITS-1:0]  rsp_distance,
   input  logic [1:0]                     rsp_region,
   output int                             fail_count,
   output int                             outstanding
);
   import psd_pkg::*;

   typedef struct {
      logic [DIST_BITS-1:0] distance;
      region_type           region;
   } dist_result_type;

   dist_result_type pending_results[$];

   // largest d below 2^DIST_BITS with d*d*den <= num
   function automatic logic [DIST_BITS-1:0] floor_root_ratio(
      logic [127:0] num, logic [127:0] den);
      logic [127:0] d;
      logic [127:0] t;
      d = '0;
      for (int b = DIST_BITS - 1; b >= 0; b--) begin
         t = d | (128'd1 << b);
         if (t * t * den <= num) d = t;
      end
      return d[DIST_BITS-1:0];
   endfunction

   function automatic logic [127:0] sq_mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   function automatic dist_result_type predict_distance(
      coord_type ax, coord_type ay, coord_type az,
      coord_type bx, coord_type by, coord_type bz,
      coord_type px, coord_type py, coord_type pz);
      longint a[3], b[3], p[3], u[3], v[3], e[3], f[3];
      longint dot_end, dot_start, cx, cy, cz;
      logic [127:0] num, den;
      dist_result_type r;
      a = '{longint'(ax), longint'(ay), longint'(az)};
      b = '{longint'(bx), longint'(by), longint'(bz)};
      p = '{longint'(px), longint'(py), longint'(pz)};
      for (int i = 0; i < 3; i++) begin
         u[i] = a[i] - p[i];
         v[i] = b[i] - p[i];
         e[i] = b[i] - a[i];
         f[i] = p[i] - a[i];
      end
      dot_end   = v[0] * e[0] + v[1] * e[1] + v[2] * e[2];
      dot_start = f[0] * e[0] + f[1] * e[1] + f[2] * e[2];
      if (a == p || b == p) begin
         r.distance = '0;
         r.region   = REGION_ENDPOINT;
      end else if (dot_end < 0) begin
         r.distance = floor_root_ratio(sq_mag(v[0]) + sq_mag(v[1]) + sq_mag(v[2]), 128'd1);
         r.region   = REGION_END;
      end else if (a == b || dot_start < 0) begin
         r.distance = floor_root_ratio(sq_mag(u[0]) + sq_mag(u[1]) + sq_mag(u[2]), 128'd1);
         r.region   = REGION_START;
      end else begin
         // perpendicular foot: |cross|^2 over |B-A|^2
         cx  = u[1] * v[2] - u[2] * v[1];
         cy  = u[2] * v[0] - u[0] * v[2];
         cz  = u[0] * v[1] - u[1] * v[0];
         num = sq_mag(cx) + sq_mag(cy) + sq_mag(cz);
         den = sq_mag(e[0]) + sq_mag(e[1]) + sq_mag(e[2]);
         r.distance = floor_root_ratio(num, den);
         r.region   = REGION_INTERIOR;
      end
      return r;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // request and result beats, sampled at the rising edge
   always @(posedge clock) begin
      dist_result_type want;
      if (!reset) begin
         if (start && !busy)
            pending_results.push_back(predict_distance(
               req_start_x, req_start_y, req_start_z,
               req_end_x, req_end_y, req_end_z,
               req_query_x, req_query_y, req_query_z));
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing outstanding: distance %0d region %0d",
                        $time, rsp_distance, rsp_region);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_distance !== want.distance) begin
                  $display("%0t: distance expected %0d actual %0d",
                           $time, want.distance, rsp_distance);
                  fail_count++;
               end
               if (rsp_region !== want.region) begin
                  $display("%0t: region expected %0d actual %0d",
                           $time, want.region, rsp_region);
                  fail_count++;
               end
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

[bench/point_segment_distance_3d_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d_tb
// Drives directed corner cases and random segment queries into the distance
// block with random gaps, and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_tb;
   import psd_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   coord_type            req_start_x, req_start_y, req_start_z;
   coord_type            req_end_x, req_end_y, req_end_z;
   coord_type            req_query_x, req_query_y, req_query_z;
   logic                 rsp_strobe;
   logic [DIST_BITS-1:0] rsp_distance;
   logic [1:0]           rsp_region;
   int                   fail_count;
   int                   outstanding;

   point_segment_distance_3d dut (.*);
   point_segment_distance_3d_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overall limit
   initial begin
      #4ms;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // one request beat; called at a falling edge, returns at a falling edge
   task automatic send_query(coord_type ax, coord_type ay, coord_type az,
                             coord_type bx, coord_type by, coord_type bz,
                             coord_type px, coord_type py, coord_type pz,
                             int gap);
      logic taken;
      req_start_x = ax; req_start_y = ay; req_start_z = az;
      req_end_x   = bx; req_end_y   = by; req_end_z   = bz;
      req_query_x = px; req_query_y = py; req_query_z = pz;
      start = 1'b1;
      do begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom());
         1: return coord_type'($urandom_range(0, 64) - 32);
         default: return coord_type'($urandom_range(0, 4096) - 2048);
      endcase
   endfunction

   initial begin
      coord_type a[3], b[3], p[3];
      int mode;
      int kind;
      start = 1'b0;
      reset = 1'b1;
      {req_start_x, req_start_y, req_start_z} = '0;
      {req_end_x, req_end_y, req_end_z} = '0;
      {req_query_x, req_query_y, req_query_z} = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: endpoints, each region, degenerate segment, extremes
      send_query(100, 200, 300, 400, 500, 600, 100, 200, 300, 0);
      send_query(100, 200, 300, 400, 500, 600, 400, 500, 600, 0);
      send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_query(0, 0, 0, 256, 0, 0, 512, 0, 0, 1);
      send_query(0, 0, 0, 256, 0, 0, -256, 0, 0, 0);
      send_query(0, 0, 0, 512, 0, 0, 256, 256, 0, 0);
      send_query(10, 10, 10, 10, 10, 10, 30, -40, 50, 2);
      send_query(-32768, -32768, -32768, 32767, 32767, 32767,
                 -32768, -32768, -32768, 0);
      send_query(-32768, -32768, -32768, -32768, -32768, -32768,
                 32767, 32767, 32767, 0);
      send_query(32767, 32767, 32767, 32767, 32767, 32767,
                 -32768, -32768, -32768, 0);
      send_query(-32768, -32768, -32768, 32767, -32768, -32768,
                 0, 32767, 32767, 0);
      send_query(-32768, 32767, -32768, 32767, -32768, 32767,
                 32767, 32767, 32767, 0);
      send_query(-32768, 32767, 0, 32767, -32768, 0, 32767, 32767, 0, 3);
      send_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
      send_query(0, 0, 0, 1, 1, 1, 1, 1, 0, 0);
      send_query(-1, -1, -1, 0, 0, 0, 32767, -32768, 32767, 0);
      send_query(0, 0, 0, 0, 0, 100, 0, 0, 100, 5);

      // random: mostly small geometry so every region turns up
      for (int n = 0; n < 500; n++) begin
         mode = $urandom_range(0, 2);
         kind = $urandom_range(0, 19);
         for (int i = 0; i < 3; i++) begin
            a[i] = rand_coord(mode);
            b[i] = rand_coord(mode);
            p[i] = rand_coord(mode);
         end
         if (kind == 0) p = a;
         else if (kind == 1) p = b;
         else if (kind == 2) b = a;
         send_query(a[0], a[1], a[2], b[0], b[1], b[2], p[0], p[1], p[2], pick_gap());
         // let the pipeline drain once mid-run
         if (n == 250) begin
            start = 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
      end
      start = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (70) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[point_segment_distance_3d.f]
design/psd_pkg.sv
design/psd_geom.sv
design/psd_square.sv
design/psd_div.sv
design/psd_sqrt.sv
design/point_segment_distance_3d.sv
bench/point_segment_distance_3d_checker.sv
bench/point_segment_distance_3d_tb.sv
